>>> sv/qrm_pkg.sv
// Shared constants for the quaternion to rotation matrix pipeline.
// Holds the default component width and the product slot indexes.
// No dependencies.
`default_nettype none

package qrm_pkg;

  localparam int COMPONENT_WIDTH = 16;

  localparam int NUM_PROD = 9;

  localparam int PXX = 0;
  localparam int PYY = 1;
  localparam int PZZ = 2;
  localparam int PXY = 3;
  localparam int PXZ = 4;
  localparam int PYZ = 5;
  localparam int PWX = 6;
  localparam int PWY = 7;
  localparam int PWZ = 8;

endpackage

`default_nettype wire

>>> sv/qrm_if.sv
// Valid/ready channel interfaces for quaternions in and matrices out.
// Width follows the component width parameter; no package dependency.
`default_nettype none

interface qrm_quat_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] qw;
  logic signed [W-1:0] qx;
  logic signed [W-1:0] qy;
  logic signed [W-1:0] qz;

  modport source (output valid, output qw, output qx, output qy, output qz, input ready);
  modport sink (input valid, input qw, input qx, input qy, input qz, output ready);
endinterface

interface qrm_mat_if #(
  parameter int W = 16
);
  logic                valid;
  logic                ready;
  logic signed [W+2:0] e00;
  logic signed [W+2:0] e10;
  logic signed [W+2:0] e20;
  logic signed [W+2:0] e01;
  logic signed [W+2:0] e11;
  logic signed [W+2:0] e21;
  logic signed [W+2:0] e02;
  logic signed [W+2:0] e12;
  logic signed [W+2:0] e22;

  modport source (
    output valid, output e00, output e10, output e20, output e01, output e11,
    output e21, output e02, output e12, output e22, input ready
  );
  modport sink (
    input valid, input e00, input e10, input e20, input e01, input e11,
    input e21, input e02, input e12, input e22, output ready
  );
endinterface

`default_nettype wire

>>> sv/qrm_products.sv
// Input register stage and the nine-multiplier product stage.
// Depends on qrm_pkg for the product slot indexes.
`default_nettype none

module qrm_products
  import qrm_pkg::*;
#(
  parameter int W = COMPONENT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [W-1:0]   qw,
  input  logic signed [W-1:0]   qx,
  input  logic signed [W-1:0]   qy,
  input  logic signed [W-1:0]   qz,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [2*W-1:0] prod [NUM_PROD]
);

  logic                s1_valid;
  logic                s1_ready;
  logic                s2_valid;
  logic                s2_ready;
  logic signed [W-1:0] w;
  logic signed [W-1:0] x;
  logic signed [W-1:0] y;
  logic signed [W-1:0] z;

  assign s2_ready  = !s2_valid || out_ready;
  assign s1_ready  = !s1_valid || s2_ready;
  assign in_ready  = s1_ready;
  assign out_valid = s2_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
    if (s1_ready && in_valid) begin
      w <= qw;
      x <= qx;
      y <= qy;
      z <= qz;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_valid;
    end
    if (s2_ready && s1_valid) begin
      prod[PXX] <= x * x;
      prod[PYY] <= y * y;
      prod[PZZ] <= z * z;
      prod[PXY] <= x * y;
      prod[PXZ] <= x * z;
      prod[PYZ] <= y * z;
      prod[PWX] <= w * x;
      prod[PWY] <= w * y;
      prod[PWZ] <= w * z;
    end
  end

endmodule

`default_nettype wire

>>> sv/qrm_combine.sv
// Sum stage: combines product pairs into the nine matrix entries and rounds.
// Depends on qrm_pkg for the product slot indexes.
`default_nettype none

module qrm_combine
  import qrm_pkg::*;
#(
  parameter int W = COMPONENT_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [2*W-1:0] prod [NUM_PROD],
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [W+2:0]   e00,
  output logic signed [W+2:0]   e10,
  output logic signed [W+2:0]   e20,
  output logic signed [W+2:0]   e01,
  output logic signed [W+2:0]   e11,
  output logic signed [W+2:0]   e21,
  output logic signed [W+2:0]   e02,
  output logic signed [W+2:0]   e12,
  output logic signed [W+2:0]   e22
);

  localparam int F  = W - 1;
  localparam int SW = 2 * W + 2;

  typedef logic signed [SW-1:0] acc_t;

  localparam acc_t ONE  = acc_t'(1);
  localparam acc_t DIAG = ONE <<< (2 * F);
  localparam acc_t HALF = ONE <<< (F - 1);

  function automatic acc_t dbl(input logic signed [2*W-1:0] p);
    dbl = acc_t'(p) <<< 1;
  endfunction

  logic s3_valid;
  acc_t sum_next [9];
  acc_t acc [9];

  assign in_ready  = !s3_valid || out_ready;
  assign out_valid = s3_valid;

  // Entry order: e00, e10, e20, e01, e11, e21, e02, e12, e22.
  always_comb begin
    sum_next[0] = DIAG - dbl(prod[PYY]) - dbl(prod[PZZ]) + HALF;
    sum_next[1] = dbl(prod[PXY]) - dbl(prod[PWZ]) + HALF;
    sum_next[2] = dbl(prod[PXZ]) + dbl(prod[PWY]) + HALF;
    sum_next[3] = dbl(prod[PXY]) + dbl(prod[PWZ]) + HALF;
    sum_next[4] = DIAG - dbl(prod[PXX]) - dbl(prod[PZZ]) + HALF;
    sum_next[5] = dbl(prod[PYZ]) - dbl(prod[PWX]) + HALF;
    sum_next[6] = dbl(prod[PXZ]) - dbl(prod[PWY]) + HALF;
    sum_next[7] = dbl(prod[PYZ]) + dbl(prod[PWX]) + HALF;
    sum_next[8] = DIAG - dbl(prod[PXX]) - dbl(prod[PYY]) + HALF;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (in_ready) begin
      s3_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      acc <= sum_next;
    end
  end

  // Dropping the low fraction bits is the floor shift of the rounding.
  assign e00 = acc[0][SW-1:F];
  assign e10 = acc[1][SW-1:F];
  assign e20 = acc[2][SW-1:F];
  assign e01 = acc[3][SW-1:F];
  assign e11 = acc[4][SW-1:F];
  assign e21 = acc[5][SW-1:F];
  assign e02 = acc[6][SW-1:F];
  assign e12 = acc[7][SW-1:F];
  assign e22 = acc[8][SW-1:F];

endmodule

`default_nettype wire

>>> sv/quaternion_to_rotation_matrix.sv
// Throughput: one transaction per cycle while the output is not stalled; a
// stalled output backs up stage by stage. An accepted quaternion passes the
// input, nine-multiplier product and sum registers to become a matrix.
// Reset clears every stage valid bit; no transaction is accepted or offered
// while reset is high. Depends on qrm_pkg, qrm_if, qrm_products, qrm_combine.
`default_nettype none

module quaternion_to_rotation_matrix
  import qrm_pkg::*;
#(
  parameter int COMPONENT_WIDTH = qrm_pkg::COMPONENT_WIDTH
) (
  input  logic clk,
  input  logic rst,
  qrm_quat_if.sink  quat,
  qrm_mat_if.source mat
);

  localparam int W = COMPONENT_WIDTH;

  logic                  prod_in_ready;
  logic                  prod_valid;
  logic                  prod_ready;
  logic signed [2*W-1:0] prod [NUM_PROD];
  logic                  comb_valid;

  assign quat.ready = prod_in_ready && !rst;
  assign mat.valid  = comb_valid && !rst;

  qrm_products #(
    .W (W)
  ) u_products (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (quat.valid),
    .in_ready  (prod_in_ready),
    .qw        (quat.qw),
    .qx        (quat.qx),
    .qy        (quat.qy),
    .qz        (quat.qz),
    .out_valid (prod_valid),
    .out_ready (prod_ready),
    .prod      (prod)
  );

  qrm_combine #(
    .W (W)
  ) u_combine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prod_valid),
    .in_ready  (prod_ready),
    .prod      (prod),
    .out_valid (comb_valid),
    .out_ready (mat.ready),
    .e00       (mat.e00),
    .e10       (mat.e10),
    .e20       (mat.e20),
    .e01       (mat.e01),
    .e11       (mat.e11),
    .e21       (mat.e21),
    .e02       (mat.e02),
    .e12       (mat.e12),
    .e22       (mat.e22)
  );

endmodule

`default_nettype wire

>>> sv/qrm_checker.sv
// Port-level checks for the quaternion to rotation matrix pipeline.
// Depends on qrm_pkg and the top level, to which it is bound.
`default_nettype none

module qrm_checker
  import qrm_pkg::*;
#(
  parameter int W = COMPONENT_WIDTH
) (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic signed [W+2:0] e00,
  input logic signed [W+2:0] e22
);

  // A transaction offered on the output holds its data until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(e00) && $stable(e22))
    else $error("output transaction changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // With nothing waiting at the output every stage can advance.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while the output is empty");

  // An accepted quaternion arrives via the sum register if the output drains.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("matrix missing three cycles after the quaternion");

endmodule

bind quaternion_to_rotation_matrix qrm_checker #(
  .W (COMPONENT_WIDTH)
) u_qrm_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (quat.valid),
  .in_ready  (quat.ready),
  .out_valid (mat.valid),
  .out_ready (mat.ready),
  .e00       (mat.e00),
  .e22       (mat.e22)
);

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for quaternion_to_rotation_matrix: directed table, then random quaternions.
// Every matrix is checked per entry against a typed row or this file's exact fixed-point predictor.
// Depends on qrm_pkg, qrm_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
  import qrm_pkg::*;

  localparam int CW = qrm_pkg::COMPONENT_WIDTH;
  localparam int FB = CW - 1;
  localparam int EW = CW + 3;
  localparam int NUM_ENTRY = 9;
  localparam int NUM_DIR = 20;
  localparam int NUM_RANDOM = 800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int MAX_REPORTS = 10;

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [EW-1:0] entry_t;
  typedef entry_t [0:NUM_ENTRY-1] mat_t;

  typedef struct packed {
    comp_t w;
    comp_t x;
    comp_t y;
    comp_t z;
  } quat_t;

  typedef struct packed {
    quat_t q;
    bit    typed;
    mat_t  m;
  } dir_row_t;

  localparam comp_t QMAX = {1'b0, {(CW-1){1'b1}}};
  localparam comp_t QMIN = {1'b1, {(CW-1){1'b0}}};
  localparam entry_t UNIT = entry_t'(1) <<< FB;
  localparam entry_t NUNIT = -UNIT;
  localparam entry_t TRIPLE_NEG = entry_t'(-3 * UNIT);
  localparam entry_t QUAD = entry_t'(4 * UNIT);
  localparam mat_t NO_MAT = '0;

  localparam string ENTRY_NAME [0:NUM_ENTRY-1] = '{
    "e00", "e10", "e20", "e01", "e11", "e21", "e02", "e12", "e22"
  };

  localparam dir_row_t DIR_ROWS [0:NUM_DIR-1] = '{
    '{'{comp_t'(0), comp_t'(0), comp_t'(0), comp_t'(0)}, 1'b1,
      '{UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT}},
    '{'{QMIN, comp_t'(0), comp_t'(0), comp_t'(0)}, 1'b1,
      '{UNIT, 0, 0, 0, UNIT, 0, 0, 0, UNIT}},
    '{'{comp_t'(0), QMIN, comp_t'(0), comp_t'(0)}, 1'b1,
      '{UNIT, 0, 0, 0, NUNIT, 0, 0, 0, NUNIT}},
    '{'{comp_t'(0), comp_t'(0), QMIN, comp_t'(0)}, 1'b1,
      '{NUNIT, 0, 0, 0, UNIT, 0, 0, 0, NUNIT}},
    '{'{comp_t'(0), comp_t'(0), comp_t'(0), QMIN}, 1'b1,
      '{NUNIT, 0, 0, 0, NUNIT, 0, 0, 0, UNIT}},
    '{'{QMIN, QMIN, QMIN, QMIN}, 1'b1,
      '{TRIPLE_NEG, 0, QUAD, QUAD, TRIPLE_NEG, 0, 0, QUAD, TRIPLE_NEG}},
    '{'{QMAX, QMAX, QMAX, QMAX}, 1'b0, NO_MAT},
    '{'{QMAX, comp_t'(0), comp_t'(0), comp_t'(0)}, 1'b0, NO_MAT},
    '{'{comp_t'(23170), comp_t'(23170), comp_t'(0), comp_t'(0)}, 1'b0, NO_MAT},
    '{'{comp_t'(23170), comp_t'(0), comp_t'(0), comp_t'(-23170)}, 1'b0, NO_MAT},
    '{'{comp_t'(16384), comp_t'(16384), comp_t'(16384), comp_t'(16384)}, 1'b0, NO_MAT},
    '{'{QMAX, QMIN, QMAX, QMIN}, 1'b0, NO_MAT},
    '{'{QMIN, QMAX, QMIN, QMAX}, 1'b0, NO_MAT},
    '{'{comp_t'(1), comp_t'(1), comp_t'(1), comp_t'(1)}, 1'b0, NO_MAT},
    '{'{comp_t'(-1), comp_t'(-1), comp_t'(-1), comp_t'(-1)}, 1'b0, NO_MAT},
    '{'{comp_t'(0), comp_t'(1), comp_t'(0), comp_t'(0)}, 1'b0, NO_MAT},
    '{'{comp_t'(0), comp_t'(64), comp_t'(128), comp_t'(0)}, 1'b0, NO_MAT},
    '{'{comp_t'(0), comp_t'(-64), comp_t'(128), comp_t'(0)}, 1'b0, NO_MAT},
    '{'{comp_t'('h5555), comp_t'('hAAAA), comp_t'('h5555), comp_t'('hAAAA)}, 1'b0, NO_MAT},
    '{'{comp_t'('hAAAA), comp_t'('h5555), comp_t'('hAAAA), comp_t'('h5555)}, 1'b0, NO_MAT}
  };

  logic clk;
  logic rst;

  qrm_quat_if #(.W(CW)) quat ();
  qrm_mat_if #(.W(CW)) mat ();

  quaternion_to_rotation_matrix #(.COMPONENT_WIDTH(CW)) uut (
    .clk (clk),
    .rst (rst),
    .quat(quat),
    .mat (mat)
  );

  mat_t expected_mats[$];
  int mismatch_count = 0;
  int cycle_count = 0;
  bit sender_calm = 1'b0;
  bit receiver_calm = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic entry_t round_entry(bit diag, longint a, longint b);
    longint acc;
    acc = (diag ? (longint'(1) << (2 * FB)) : 64'sd0) + 2 * a + 2 * b
          + (longint'(1) << (FB - 1));
    return entry_t'(acc >>> FB);
  endfunction

  function automatic mat_t rotation_of(quat_t q);
    longint w, x, y, z;
    mat_t m;
    w = q.w;
    x = q.x;
    y = q.y;
    z = q.z;
    m[0] = round_entry(1'b1, -(y * y), -(z * z));
    m[1] = round_entry(1'b0, x * y, -(w * z));
    m[2] = round_entry(1'b0, x * z, w * y);
    m[3] = round_entry(1'b0, x * y, w * z);
    m[4] = round_entry(1'b1, -(x * x), -(z * z));
    m[5] = round_entry(1'b0, y * z, -(w * x));
    m[6] = round_entry(1'b0, x * z, -(w * y));
    m[7] = round_entry(1'b0, y * z, w * x);
    m[8] = round_entry(1'b1, -(x * x), -(y * y));
    return m;
  endfunction

  function automatic int draw_wait(bit calm);
    if (calm) begin
      return 0;
    end
    if ($urandom_range(0, 2) == 0) begin
      return $urandom_range(0, 16);
    end
    return $urandom_range(0, 2);
  endfunction

  function automatic comp_t pick_comp(int kind);
    case (kind)
      0: return comp_t'($urandom);
      1: return comp_t'(int'($urandom_range(0, 512)) - 256);
      default: begin
        case ($urandom_range(0, 4))
          0: return QMAX;
          1: return QMIN;
          2: return comp_t'(0);
          3: return comp_t'(1);
          default: return comp_t'(-1);
        endcase
      end
    endcase
  endfunction

  function automatic quat_t random_quat();
    real a [4];
    real norm;
    quat_t q;
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 4 || sel == 5) begin
      norm = 0.0;
      for (int i = 0; i < 4; i++) begin
        a[i] = (real'($urandom_range(0, 2000000)) - 1000000.0) / 1000000.0;
        norm += a[i] * a[i];
      end
      if (norm < 1.0e-6) begin
        a[0] = 1.0;
        norm = 1.0;
      end
      norm = $sqrt(norm);
      q.w = comp_t'($rtoi(a[0] / norm * 32767.0));
      q.x = comp_t'($rtoi(a[1] / norm * 32767.0));
      q.y = comp_t'($rtoi(a[2] / norm * 32767.0));
      q.z = comp_t'($rtoi(a[3] / norm * 32767.0));
    end else if (sel == 6) begin
      q = '{pick_comp(1), pick_comp(1), pick_comp(1), pick_comp(1)};
    end else if (sel == 7) begin
      q = '{pick_comp($urandom_range(0, 2)), pick_comp($urandom_range(0, 2)),
            pick_comp($urandom_range(0, 2)), pick_comp($urandom_range(0, 2))};
    end else if (sel == 8) begin
      q = '{pick_comp(2), pick_comp(2), pick_comp(2), pick_comp(2)};
    end else begin
      q = '{pick_comp(0), pick_comp(0), pick_comp(0), pick_comp(0)};
    end
    return q;
  endfunction

  task automatic send_quat(input quat_t q, input bit typed, input mat_t m);
    int gap;
    gap = draw_wait(sender_calm);
    if (gap > 0) begin
      quat.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    quat.valid <= 1'b1;
    quat.qw <= q.w;
    quat.qx <= q.x;
    quat.qy <= q.y;
    quat.qz <= q.z;
    do @(posedge clk); while (!quat.ready);
    expected_mats.push_back(typed ? m : rotation_of(q));
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    mat_t got;
    mat_t want;
    if (!rst && mat.valid && mat.ready) begin
      got[0] = mat.e00;
      got[1] = mat.e10;
      got[2] = mat.e20;
      got[3] = mat.e01;
      got[4] = mat.e11;
      got[5] = mat.e21;
      got[6] = mat.e02;
      got[7] = mat.e12;
      got[8] = mat.e22;
      if (expected_mats.size() == 0) begin
        if (mismatch_count < MAX_REPORTS) begin
          $display("Unexpected matrix transaction at cycle %0d", cycle_count);
        end
        mismatch_count++;
      end else begin
        want = expected_mats.pop_front();
        for (int i = 0; i < NUM_ENTRY; i++) begin
          if (got[i] !== want[i]) begin
            if (mismatch_count < MAX_REPORTS) begin
              $display("Mismatch on %s at cycle %0d: expected %0d, got %0d",
                       ENTRY_NAME[i], cycle_count, want[i], got[i]);
            end
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    int stall;
    int taken;
    mat.ready <= 1'b0;
    taken = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 64 == 0) begin
        receiver_calm = ($urandom_range(0, 2) == 0);
      end
      stall = draw_wait(receiver_calm);
      if (stall > 0) begin
        mat.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      mat.ready <= 1'b1;
      do @(posedge clk); while (!mat.valid);
      taken++;
    end
  end

  initial begin
    rst <= 1'b1;
    quat.valid <= 1'b0;
    quat.qw <= '0;
    quat.qx <= '0;
    quat.qy <= '0;
    quat.qz <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      send_quat(DIR_ROWS[i].q, DIR_ROWS[i].typed, DIR_ROWS[i].m);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n % 60 == 0) begin
        sender_calm = ($urandom_range(0, 2) == 0);
      end
      if (n == NUM_RANDOM / 2) begin
        quat.valid <= 1'b0;
        while (expected_mats.size() != 0) @(posedge clk);
      end
      send_quat(random_quat(), 1'b0, NO_MAT);
    end

    quat.valid <= 1'b0;
    while (expected_mats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_mats.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
